### src/window_variance_saturation_detector_defines.svh
// Assertion macros shared by the detector RTL.
// Pulled in by the top level; depends on nothing.
`ifndef WINDOW_VARIANCE_SATURATION_DETECTOR_DEFINES_SVH
`define WINDOW_VARIANCE_SATURATION_DETECTOR_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define WVSD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define WVSD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### src/wvsd_pkg.sv
// Package for the window variance saturation detector: fixed widths,
// register codes, reset values and the stage control struct. No dependencies.
package wvsd_pkg;

   localparam int STABLE_W  = 17;
   localparam int LIMIT_W   = 16;
   localparam int BOOST_W   = 12;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DAT_W = 16;
   localparam int RSP_W     = 16;

   localparam logic [STABLE_W-1:0] STABLE_MAX  = '1;
   localparam logic [BOOST_W-1:0]  BOOST_ONE   = 12'd256;
   localparam logic [LIMIT_W-1:0]  LIMIT_RESET = 16'd30;
   localparam logic [BOOST_W-1:0]  BOOST_RESET = 12'd512;

   localparam logic [CSR_IDX_W-1:0] REG_STABLE_LIMIT = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BOOST_MULT   = 8'd1;

   typedef struct packed {
      logic valid;
      logic test;
   } stage_ctl_type;

endpackage

### src/wvsd_ring.sv
// Sample ring memory: one write port, one read port, registered read data.
// Standalone; no package needed.
module wvsd_ring #(
   parameter int DEPTH  = 20,
   parameter int DATA_W = 10,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // hold read data until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### src/wvsd_accum.sv
// Running sum and sum of squares update, evicting the oldest sample once the
// window is full. Uses wvsd_pkg for the stage control struct.
module wvsd_accum import wvsd_pkg::*; #(
   parameter int SIZE_BITS = 10,
   parameter int CNT_W     = 5,
   parameter int SUM_W     = 15,
   parameter int SQ_W      = 25,
   parameter int THR_W     = 11
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   output logic                   in_ready,
   input  logic [SIZE_BITS-1:0]   in_sample,
   input  logic [2*SIZE_BITS-1:0] in_sample_sq,
   input  logic [SIZE_BITS-1:0]   in_old,
   input  logic                   in_full,
   input  logic                   in_test,
   input  logic [CNT_W-1:0]       in_n,
   input  logic [THR_W-1:0]       in_thr,
   input  logic                   out_ready,
   output stage_ctl_type          out_ctl,
   output logic [CNT_W-1:0]       out_n,
   output logic [THR_W-1:0]       out_thr,
   output logic [SUM_W-1:0]       out_sum,
   output logic [SQ_W-1:0]        out_sumsq
);

   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [SQ_W-1:0]        sumsq_ff, sumsq_in;
   logic [SIZE_BITS-1:0]   old_eff;
   logic [2*SIZE_BITS-1:0] old_sq;
   logic                   move;
   stage_ctl_type          ctl_ff, ctl_in;
   logic [CNT_W-1:0]       n_ff;
   logic [THR_W-1:0]       thr_ff;
   logic [SUM_W-1:0]       sum2_ff;
   logic [SQ_W-1:0]        sumsq2_ff;

   assign in_ready = !ctl_ff.valid || out_ready;
   assign move     = in_valid && in_ready;

   assign old_eff = in_full ? in_old : '0;
   assign old_sq  = (2*SIZE_BITS)'(old_eff) * (2*SIZE_BITS)'(old_eff);

   always_comb begin
      sum_in   = sum_ff - SUM_W'(old_eff) + SUM_W'(in_sample);
      sumsq_in = sumsq_ff - SQ_W'(old_sq) + SQ_W'(in_sample_sq);
   end

   always_comb begin
      ctl_in = ctl_ff;
      if (move) begin
         ctl_in.valid = 1'b1;
         ctl_in.test  = in_test;
      end else if (out_ready) begin
         ctl_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff   <= '0;
         sumsq_ff <= '0;
         ctl_ff   <= '0;
      end else begin
         ctl_ff <= ctl_in;
         if (move) begin
            sum_ff   <= sum_in;
            sumsq_ff <= sumsq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move) begin
         n_ff      <= in_n;
         thr_ff    <= in_thr;
         sum2_ff   <= sum_in;
         sumsq2_ff <= sumsq_in;
      end
   end

   assign out_ctl   = ctl_ff;
   assign out_n     = n_ff;
   assign out_thr   = thr_ff;
   assign out_sum   = sum2_ff;
   assign out_sumsq = sumsq2_ff;

endmodule

### src/wvsd_judge.sv
// Variance test, stable counter and result register: products in one stage,
// compare and count in the next. Uses wvsd_pkg for widths and constants.
module wvsd_judge import wvsd_pkg::*; #(
   parameter int CNT_W = 5,
   parameter int SUM_W = 15,
   parameter int SQ_W  = 25,
   parameter int THR_W = 11
) (
   input  logic               clock,
   input  logic               reset,
   input  stage_ctl_type      in_ctl,
   output logic               in_ready,
   input  logic [CNT_W-1:0]   in_n,
   input  logic [THR_W-1:0]   in_thr,
   input  logic [SUM_W-1:0]   in_sum,
   input  logic [SQ_W-1:0]    in_sumsq,
   input  logic [LIMIT_W-1:0] limit,
   input  logic [BOOST_W-1:0] boost,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_saturated,
   output logic [BOOST_W-1:0] rsp_boost
);

   localparam int P1_W  = CNT_W + SQ_W;
   localparam int P2_W  = 2 * SUM_W;
   localparam int LHS_W = (P1_W > P2_W) ? P1_W : P2_W;

   stage_ctl_type      ctl3_ff, ctl3_in;
   logic [P1_W-1:0]    prod_ff;
   logic [P2_W-1:0]    sqsum_ff;
   logic [THR_W-1:0]   thr3_ff;
   logic               move2, move3, out_free;
   logic [LHS_W-1:0]   lhs;
   logic               pass;
   logic [STABLE_W-1:0] stable_ff, stable_in;
   logic               sat;
   logic               valid_ff, valid_in;
   logic               sat_ff;
   logic [BOOST_W-1:0] boost_ff;

   assign out_free = !valid_ff || rsp_ready;
   assign in_ready = !ctl3_ff.valid || out_free;
   assign move2    = in_ctl.valid && in_ready;
   assign move3    = ctl3_ff.valid && out_free;

   always_comb begin
      ctl3_in = ctl3_ff;
      if (move2) begin
         ctl3_in = in_ctl;
      end else if (out_free) begin
         ctl3_in.valid = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (move2) begin
         prod_ff  <= P1_W'(in_n) * P1_W'(in_sumsq);
         sqsum_ff <= P2_W'(in_sum) * P2_W'(in_sum);
         thr3_ff  <= in_thr;
      end
   end

   // n*sumsq never falls below sum^2, so the difference stays non-negative
   assign lhs  = LHS_W'(prod_ff) - LHS_W'(sqsum_ff);
   assign pass = lhs < LHS_W'(thr3_ff);

   always_comb begin
      stable_in = stable_ff;
      if (ctl3_ff.test) begin
         if (!pass) begin
            stable_in = '0;
         end else if (stable_ff != STABLE_MAX) begin
            stable_in = stable_ff + 1'b1;
         end
      end
   end

   assign sat = ctl3_ff.test && (stable_in > STABLE_W'(limit));

   always_comb begin
      valid_in = valid_ff;
      if (move3) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl3_ff   <= '0;
         stable_ff <= '0;
         valid_ff  <= 1'b0;
      end else begin
         ctl3_ff  <= ctl3_in;
         valid_ff <= valid_in;
         if (move3) begin
            stable_ff <= stable_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (move3) begin
         sat_ff   <= sat;
         boost_ff <= sat ? boost : BOOST_ONE;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_saturated = sat_ff;
   assign rsp_boost     = boost_ff;

endmodule

### src/window_variance_saturation_detector.sv
// Top level of the window variance saturation detector: input stage, ring
// memory, accumulators, variance judge, control registers. Uses wvsd_pkg.
//
//  channel | dir | handshake              | payload
//  req     | in  | req_tvalid/req_tready  | req_tdata: context_size
//  rsp     | out | rsp_tvalid/rsp_tready  | rsp_tdata: saturated, boost_q8
//  csr     | in  | csr_valid/csr_ready    | csr_index, csr_wdata
//
// One sample per cycle while no stage is stalled. From the transfer edge, with
// the ring read at that edge, a sample passes the sum update and products,
// then compare and count into the result register. The registered ring read and
// the product stage set the depth. Each stage holds while the one after it is
// full and stalled, so input transfers go on until every stage is occupied.
// Reset clears the counters and sums at once; the ring needs no clearing pass.
`include "window_variance_saturation_detector_defines.svh"

module window_variance_saturation_detector import wvsd_pkg::*; #(
   parameter int WINDOW    = 20,
   parameter int MIN_FILL  = 10,
   parameter int SIZE_BITS = 10,
   localparam int REQ_W = ((SIZE_BITS + 7) / 8) * 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [REQ_W-1:0]     req_tdata,   // [SIZE_BITS-1:0] context_size
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [RSP_W-1:0]     rsp_tdata,   // [0] saturated, [12:1] boost_q8
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   localparam int SLOT_W = $clog2(WINDOW);
   localparam int CNT_W  = $clog2(WINDOW + 1);
   localparam int SUM_W  = SIZE_BITS + CNT_W;
   localparam int SQ_W   = 2 * SIZE_BITS + CNT_W;
   localparam int THR_W  = 2 * CNT_W + 1;

   logic [LIMIT_W-1:0] limit_ff, limit_in;
   logic [BOOST_W-1:0] boost_ff, boost_in;

   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  fill_ff, fill_in;
   logic              accept, full_now;
   logic [SIZE_BITS-1:0] sample;

   logic                   v1_ff, v1_in;
   logic [SIZE_BITS-1:0]   s1_sample_ff;
   logic [2*SIZE_BITS-1:0] s1_sq_ff;
   logic [SLOT_W-1:0]      s1_slot_ff;
   logic                   s1_full_ff;
   logic                   s1_test_ff;
   logic [CNT_W-1:0]       s1_n_ff;
   logic [THR_W-1:0]       s1_thr_ff;

   logic                 accum_ready, judge_ready, move1;
   logic [SIZE_BITS-1:0] old_sample;
   stage_ctl_type        ctl2;
   logic [CNT_W-1:0]     n2;
   logic [THR_W-1:0]     thr2;
   logic [SUM_W-1:0]     sum2;
   logic [SQ_W-1:0]      sumsq2;
   logic                 rsp_sat;
   logic [BOOST_W-1:0]   rsp_boost;

   // control registers
   assign csr_ready = 1'b1;

   always_comb begin
      limit_in = limit_ff;
      boost_in = boost_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_STABLE_LIMIT: limit_in = csr_wdata;
            REG_BOOST_MULT:   boost_in = csr_wdata[BOOST_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
         boost_ff <= BOOST_RESET;
      end else begin
         limit_ff <= limit_in;
         boost_ff <= boost_in;
      end
   end

   // input stage: slot and fill bookkeeping, ring read issue
   assign accept     = req_tvalid && req_tready;
   assign sample     = req_tdata[SIZE_BITS-1:0];
   assign full_now   = fill_ff == CNT_W'(WINDOW);
   assign req_tready = !v1_ff || accum_ready;
   assign move1      = v1_ff && accum_ready;

   always_comb begin
      slot_in = slot_ff;
      fill_in = fill_ff;
      if (accept) begin
         slot_in = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
         if (!full_now) begin
            fill_in = fill_ff + 1'b1;
         end
      end
      v1_in = v1_ff;
      if (accept) begin
         v1_in = 1'b1;
      end else if (accum_ready) begin
         v1_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
         v1_ff   <= 1'b0;
      end else begin
         slot_ff <= slot_in;
         fill_ff <= fill_in;
         v1_ff   <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_sample_ff <= sample;
         s1_sq_ff     <= (2*SIZE_BITS)'(sample) * (2*SIZE_BITS)'(sample);
         s1_slot_ff   <= slot_ff;
         s1_full_ff   <= full_now;
         s1_n_ff      <= fill_in;
         s1_test_ff   <= 32'(fill_in) >= MIN_FILL;
         s1_thr_ff    <= THR_W'((THR_W'(fill_in) * THR_W'(fill_in)) << 1);
      end
   end

   // write the new sample as it leaves for the sum update
   wvsd_ring #(
      .DEPTH  (WINDOW),
      .DATA_W (SIZE_BITS)
   ) u_ring (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (slot_ff),
      .rd_data (old_sample),
      .wr_en   (move1),
      .wr_addr (s1_slot_ff),
      .wr_data (s1_sample_ff)
   );

   wvsd_accum #(
      .SIZE_BITS (SIZE_BITS),
      .CNT_W     (CNT_W),
      .SUM_W     (SUM_W),
      .SQ_W      (SQ_W),
      .THR_W     (THR_W)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (v1_ff),
      .in_ready     (accum_ready),
      .in_sample    (s1_sample_ff),
      .in_sample_sq (s1_sq_ff),
      .in_old       (old_sample),
      .in_full      (s1_full_ff),
      .in_test      (s1_test_ff),
      .in_n         (s1_n_ff),
      .in_thr       (s1_thr_ff),
      .out_ready    (judge_ready),
      .out_ctl      (ctl2),
      .out_n        (n2),
      .out_thr      (thr2),
      .out_sum      (sum2),
      .out_sumsq    (sumsq2)
   );

   wvsd_judge #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W),
      .SQ_W  (SQ_W),
      .THR_W (THR_W)
   ) u_judge (
      .clock         (clock),
      .reset         (reset),
      .in_ctl        (ctl2),
      .in_ready      (judge_ready),
      .in_n          (n2),
      .in_thr        (thr2),
      .in_sum        (sum2),
      .in_sumsq      (sumsq2),
      .limit         (limit_ff),
      .boost         (boost_ff),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_saturated (rsp_sat),
      .rsp_boost     (rsp_boost)
   );

   assign rsp_tdata = {(RSP_W - BOOST_W - 1)'(0), rsp_boost, rsp_sat};

   `WVSD_ASSERT_NOW(a_fill_bound, clock, reset, 1'b1, fill_ff <= CNT_W'(WINDOW), "fill overrun")
   `WVSD_ASSERT_NOW(a_slot_bound, clock, reset, 1'b1, slot_ff < SLOT_W'(WINDOW), "slot overrun")
   `WVSD_ASSERT_NEXT(a_accept_s1, clock, reset, accept, v1_ff, "transfer lost at stage 1")
   `WVSD_ASSERT_NOW(a_boost_one, clock, reset, rsp_tvalid && !rsp_sat, rsp_boost == BOOST_ONE, "boost")

endmodule

### test/tb_top.sv
// Self-checking bench for window_variance_saturation_detector: a predictor of the
// sample window, stable-frame counter and boost output checks every response.
// Depends on wvsd_pkg and the detector RTL only.
module tb_top import wvsd_pkg::*; ();

   localparam int WINDOW        = 20;
   localparam int MIN_FILL      = 10;
   localparam int SIZE_BITS     = 10;
   localparam int REQ_W         = 16;
   localparam int HOLD_CYCLES   = 80;
   localparam int SETTLE_CYCLES = 12;
   localparam int CYCLE_LIMIT   = 100_000;
   localparam int VERDICT_DEPTH = 64;

   typedef struct packed {
      logic [BOOST_W-1:0] boost;
      logic               saturated;
   } verdict_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_W-1:0]     req_tdata = '0;     // [9:0] context_size
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [RSP_W-1:0]     rsp_tdata;          // [0] saturated, [12:1] boost_q8
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   // predictor state
   logic [SIZE_BITS-1:0] ring_sizes [WINDOW];
   int                   ring_slot = 0;
   int                   ring_fill = 0;
   logic [63:0]          size_sum = '0;
   logic [63:0]          size_sumsq = '0;
   logic [STABLE_W-1:0]  stable_run = '0;
   logic [LIMIT_W-1:0]   limit_cfg = LIMIT_RESET;
   logic [BOOST_W-1:0]   boost_cfg = BOOST_RESET;

   // pending responses in transfer order
   verdict_type expected_verdicts [VERDICT_DEPTH];
   int          verdict_head = 0;
   int          verdict_tail = 0;

   int       error_count = 0;
   int       cycle_count = 0;
   int       send_idle_pct = 19;
   int       recv_idle_pct = 76;
   int       hold_reqs = 0;
   int       hold_seen = 0;
   int       hold_left = 0;

   window_variance_saturation_detector uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Update window sums and stable counter for one sample; return the response.
   function automatic verdict_type predict_verdict(input logic [SIZE_BITS-1:0] size);
      logic [63:0] oldest;
      logic [63:0] sample;
      logic [63:0] n;
      logic [63:0] spread;
      verdict_type v;
      sample = 64'(size);
      if (ring_fill >= WINDOW) begin
         oldest = 64'(ring_sizes[ring_slot]);
         size_sum   -= oldest;
         size_sumsq -= oldest * oldest;
      end else begin
         ring_fill++;
      end
      ring_sizes[ring_slot] = size;
      size_sum   += sample;
      size_sumsq += sample * sample;
      ring_slot = (ring_slot + 1) % WINDOW;

      v.saturated = 1'b0;
      if (ring_fill >= MIN_FILL) begin
         n = 64'(ring_fill);
         spread = n * size_sumsq - size_sum * size_sum;
         if (spread < 64'd2 * n * n) begin
            if (stable_run != STABLE_MAX)
               stable_run++;
         end else begin
            stable_run = '0;
         end
         v.saturated = (stable_run > STABLE_W'(limit_cfg));
      end
      v.boost = v.saturated ? boost_cfg : BOOST_ONE;
      return v;
   endfunction

   function automatic int pending_verdicts();
      return verdict_tail - verdict_head;
   endfunction

   // Response handshake, with a long hold-off on request.
   always @(posedge clock) begin
      if (hold_seen != hold_reqs) begin
         hold_seen  <= hold_reqs;
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin : check_responses
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_verdicts() == 0) begin
            $error("response with nothing pending: tdata %h", rsp_tdata);
            error_count++;
         end else begin
            want = expected_verdicts[verdict_head % VERDICT_DEPTH];
            verdict_head++;
            if (rsp_tdata[0] !== want.saturated) begin
               $error("saturated: expected %0d, actual %0d", want.saturated, rsp_tdata[0]);
               error_count++;
            end
            if (rsp_tdata[12:1] !== want.boost) begin
               $error("boost_q8: expected %0d, actual %0d", want.boost, rsp_tdata[12:1]);
               error_count++;
            end
         end
      end
   end

   task automatic send_sample(input logic [SIZE_BITS-1:0] size);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - SIZE_BITS){1'b0}}, size};
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      expected_verdicts[verdict_tail % VERDICT_DEPTH] = predict_verdict(size);
      verdict_tail++;
   endtask

   task automatic wait_for_results();
      req_tvalid <= 1'b0;
      while (pending_verdicts() != 0)
         @(posedge clock);
   endtask

   // Write both registers back to back; keep valid high across the pair.
   task automatic write_registers(input logic [LIMIT_W-1:0] limit,
                                  input logic [BOOST_W-1:0] boost);
      csr_valid <= 1'b1;
      csr_index <= REG_STABLE_LIMIT;
      csr_wdata <= limit;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      limit_cfg = limit;
      csr_index <= REG_BOOST_MULT;
      csr_wdata <= {{(CSR_DAT_W - BOOST_W){1'b0}}, boost};
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      boost_cfg = boost;
      csr_valid <= 1'b0;
   endtask

   // Field extremes, partial window, eviction and the variance boundary
   // (deviation +-2 in half the window gives variance exactly 2, which fails).
   task automatic test_fill_and_variance_edge();
      send_sample(10'd0);
      send_sample(10'd1023);
      repeat (5) send_sample(10'd510);
      repeat (5) send_sample(10'd514);
      repeat (10) send_sample(10'd512);
      repeat (3) send_sample(10'd512);
      wait_for_results();
      write_registers(16'd0, 12'd4095);
      repeat (2) send_sample(10'd512);
      wait_for_results();
   endtask

   // Mostly near-constant runs with small jitter, some outliers and noise bursts.
   task automatic send_stable_runs(input int count);
      int sent;
      int len;
      int base;
      int spread;
      int v;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(99) < 80) begin
            base   = int'($urandom_range(1023));
            spread = int'($urandom_range(4));
            len    = int'($urandom_range(60, 5));
            repeat (len) begin
               if ($urandom_range(99) < 3)
                  v = int'($urandom_range(1023));
               else
                  v = int'($urandom_range(spread)) + base - spread / 2;
               if (v < 0)
                  v = 0;
               else if (v > 1023)
                  v = 1023;
               send_sample(v[SIZE_BITS-1:0]);
               sent++;
            end
         end else begin
            len = int'($urandom_range(8, 1));
            repeat (len) begin
               send_sample(SIZE_BITS'($urandom_range(1023)));
               sent++;
            end
         end
      end
   endtask

   task automatic test_random_traffic(input int send_pct, input int recv_pct,
                                      input logic [LIMIT_W-1:0] limit,
                                      input logic [BOOST_W-1:0] boost, input int count);
      write_registers(limit, boost);
      send_idle_pct = send_pct;
      recv_idle_pct <= recv_pct;
      send_stable_runs(count);
      wait_for_results();
   endtask

   // Hold the response side long enough that the pipeline fills and the
   // request side stalls, then pause input until all responses are back.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      hold_reqs <= hold_reqs + 1;
      send_stable_runs(40);
      wait_for_results();
   endtask

   // Run one constant sample long enough to cross a high limit and stay saturated.
   task automatic test_long_stable_run();
      logic [SIZE_BITS-1:0] base;
      base = SIZE_BITS'($urandom_range(1023));
      write_registers(16'd150, 12'd4095);
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      repeat (200)
         send_sample(base);
      wait_for_results();
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fill_and_variance_edge();
      test_random_traffic(19, 76, 16'd0, 12'd0, 540);
      test_random_traffic(76, 19, 16'd5, 12'd4095, 540);
      test_backpressure();
      test_long_stable_run();
      test_random_traffic(0, 0, LIMIT_W'($urandom_range(40)), BOOST_W'($urandom_range(4095)),
                          500);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0 && pending_verdicts() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

### filelist.f
+incdir+src
src/wvsd_pkg.sv
src/wvsd_ring.sv
src/wvsd_accum.sv
src/wvsd_judge.sv
src/window_variance_saturation_detector.sv
test/tb_top.sv
